[design/kpsc_pkg.sv]
// Package for the keypad row-scan lamp controller: defaults, drive codes,
// lane control and result types, and the lamp code function.
// Depends on nothing; the lane, merge and top design files import it.
package kpsc_pkg;

  // Default configuration of the block.
  localparam int ROWS_DEF  = 3;
  localparam int KEYS_DEF  = 24;
  localparam int TICKS_DEF = 100;

  // Rows that have a sense input and a drive output.
  localparam int PORT_ROWS = 3;

  // Drive codes and the "no key" value.
  localparam logic [6:0] DRIVE_BASE  = 7'h71;
  localparam logic [6:0] DRIVE_BLANK = 7'h7F;
  localparam logic [7:0] NO_KEY      = 8'hFF;
  localparam logic [6:0] SENSE_IDLE  = 7'h7F;

  // Request codes.
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Per-lane control decoded from one request.
  typedef struct packed {
    logic       upd;         // host update aimed at this row
    logic [7:0] upd_lamp;
    logic       scan;        // linked tick: run the scan step
    logic       clear;       // link state changed: clear the row
    logic       chase;       // chase step writes this row's drive
    logic [7:0] chase_lamp;
  } kpsc_lane_ctl_t;

  // One result item.
  typedef struct packed {
    logic [6:0] lamp_drive0;
    logic [6:0] lamp_drive1;
    logic [6:0] lamp_drive2;
    logic       status_led;
    logic       press_valid;
    logic [1:0] press_row;
    logic [4:0] press_key;
  } kpsc_res_t;

  // Drive code for a lamp number: group bit cleared for lamps 0..23, low bits in bits 3..1.
  function automatic logic [6:0] lamp_code(input logic [7:0] lamp);
    logic [6:0] v;
    v = DRIVE_BASE;
    if (lamp <= 8'd7) begin
      v[6] = 1'b0;
    end else if (lamp <= 8'd15) begin
      v[5] = 1'b0;
    end else if (lamp <= 8'd23) begin
      v[4] = 1'b0;
    end
    v[3:1] = v[3:1] | lamp[2:0];
    return v;
  endfunction

endpackage

[design/kpsc_in_if.sv]
// Request channel of the keypad row-scan lamp controller.
// Depends on nothing; carries valid, ready and the request fields.
interface kpsc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       usb_configured;
  logic [6:0] row0_sense;
  logic [6:0] row1_sense;
  logic [6:0] row2_sense;
  logic [7:0] update_row;
  logic [7:0] update_lamp;

  modport source (output valid, cmd, usb_configured, row0_sense, row1_sense, row2_sense,
                  update_row, update_lamp, input ready);
  modport sink   (input valid, cmd, usb_configured, row0_sense, row1_sense, row2_sense,
                  update_row, update_lamp, output ready);
endinterface

[design/kpsc_out_if.sv]
// Result channel of the keypad row-scan lamp controller.
// Depends on nothing; carries valid, ready and the result fields.
interface kpsc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] lamp_drive0;
  logic [6:0] lamp_drive1;
  logic [6:0] lamp_drive2;
  logic       status_led;
  logic       press_valid;
  logic [1:0] press_row;
  logic [4:0] press_key;

  modport source (output valid, lamp_drive0, lamp_drive1, lamp_drive2, status_led,
                  press_valid, press_row, press_key, input ready);
  modport sink   (input valid, lamp_drive0, lamp_drive1, lamp_drive2, status_led,
                  press_valid, press_row, press_key, output ready);
endinterface

[design/kpsc_lane.sv]
// One row lane: held key, scan phase and drive latch of a single lamp row.
// Depends on kpsc_pkg for the lane control struct and the lamp code.
module kpsc_lane (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  kpsc_pkg::kpsc_lane_ctl_t ctl,
  input  logic [6:0]              sense,
  output logic [6:0]              drive_nxt,
  output logic                    press,
  output logic [4:0]              press_key
);
  import kpsc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [6:0] drive_r;

  logic [7:0] held_c;
  phase_t     phase_c;
  logic [6:0] drive_c;
  logic       down;
  logic       got;
  logic [7:0] dec_key;

  // Group decode of the sensed key; the highest group wins.
  always_comb begin
    got = 1'b1;
    if (!sense[4]) begin
      dec_key = {3'b000, 2'b10, sense[3:1]};
    end else if (!sense[5]) begin
      dec_key = {3'b000, 2'b01, sense[3:1]};
    end else if (!sense[6]) begin
      dec_key = {5'b00000, sense[3:1]};
    end else begin
      dec_key = 8'd0;
      got     = 1'b0;
    end
  end

  assign down = !sense[0];

  // Next row state: clear first, then the host update, the scan step or the chase write.
  always_comb begin
    held_c  = ctl.clear ? NO_KEY : held_r;
    phase_c = ctl.clear ? PH_IDLE : phase_r;
    drive_c = ctl.clear ? DRIVE_BLANK : drive_r;

    held_nxt  = held_c;
    phase_nxt = phase_c;
    drive_nxt = drive_c;
    press     = 1'b0;

    if (ctl.upd) begin
      held_nxt  = ctl.upd_lamp;
      phase_nxt = PH_IDLE;
      drive_nxt = lamp_code(ctl.upd_lamp);
    end else if (ctl.scan) begin
      unique case (phase_c)
        PH_IDLE: begin
          if (down) begin
            drive_nxt = DRIVE_BLANK;
            phase_nxt = PH_CONFIRM;
          end
        end
        PH_CONFIRM: begin
          if (down) begin
            // With no group bit low the old key is kept and relit.
            if (got) begin
              held_nxt = dec_key;
            end
            drive_nxt = lamp_code(got ? dec_key : held_c);
            phase_nxt = PH_RELEASE;
            press     = got;
          end else begin
            drive_nxt = lamp_code(held_c);
            phase_nxt = PH_IDLE;
          end
        end
        PH_RELEASE: begin
          if (!down) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = phase_c;
        end
      endcase
    end else if (ctl.chase) begin
      drive_nxt = lamp_code(ctl.chase_lamp);
    end
  end

  assign press_key = held_nxt[4:0];

  // Row state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 8'd0;
      phase_r <= PH_IDLE;
      drive_r <= lamp_code(8'd0);
    end else if (fire) begin
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      drive_r <= drive_nxt;
    end
  end

endmodule

[design/kpsc_merge.sv]
// Merge stage: picks the reported press over the lanes, builds the result
// and holds it in an output register with a skid entry behind it.
// Depends on kpsc_pkg and the result channel interface.
module kpsc_merge #(
  parameter int ROWS = kpsc_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [6:0] lane_drive [ROWS],
  input  logic       lane_press [ROWS],
  input  logic [4:0] lane_key   [ROWS],
  input  logic       led_nxt,
  output logic       in_ready,
  kpsc_out_if.source out_ch
);
  import kpsc_pkg::*;

  kpsc_res_t res;
  kpsc_res_t main_r;
  kpsc_res_t skid_r;
  logic      main_vld_r;
  logic      skid_vld_r;
  logic      out_fire;

  // Press priority: the highest row that reports wins.
  always_comb begin
    res             = '0;
    res.status_led  = led_nxt;
    res.lamp_drive0 = lane_drive[0];
    if (ROWS > 1) begin
      res.lamp_drive1 = lane_drive[1 % ROWS];
    end
    if (ROWS > 2) begin
      res.lamp_drive2 = lane_drive[2 % ROWS];
    end
    for (int r = 0; r < ROWS; r++) begin
      if (lane_press[r]) begin
        res.press_valid = 1'b1;
        res.press_row   = 2'(r);
        res.press_key   = lane_key[r];
      end
    end
  end

  assign out_fire = main_vld_r && out_ch.ready;
  assign in_ready = !skid_vld_r;

  // Output register and skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_fire) begin
      if (skid_vld_r) begin
        main_r     <= skid_r;
        skid_vld_r <= 1'b0;
      end else if (in_fire) begin
        main_r <= res;
      end else begin
        main_vld_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!main_vld_r) begin
        main_r     <= res;
        main_vld_r <= 1'b1;
      end else begin
        skid_r     <= res;
        skid_vld_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid       = main_vld_r;
  assign out_ch.lamp_drive0 = main_r.lamp_drive0;
  assign out_ch.lamp_drive1 = main_r.lamp_drive1;
  assign out_ch.lamp_drive2 = main_r.lamp_drive2;
  assign out_ch.status_led  = main_r.status_led;
  assign out_ch.press_valid = main_r.press_valid;
  assign out_ch.press_row   = main_r.press_row;
  assign out_ch.press_key   = main_r.press_key;

endmodule

[design/keypad_row_scan_lamp_controller_top.sv]
// Keypad row-scan lamp controller top level; uses kpsc_pkg, both channel interfaces,
// kpsc_lane and kpsc_merge for blink and chase timing, link tracking and the row lanes.
// Each accepted request's result is registered in the output register or the skid entry.
// Throughput: one request per cycle while the skid is empty; each request is a state
// update shared by all row lanes; the skid entry keeps input open while a result waits.
// Reset (synchronous, rst_n low): rows hold lamp 0 in idle phase, LED off, chase at 255.
module keypad_row_scan_lamp_controller_top #(
  parameter int ROWS             = kpsc_pkg::ROWS_DEF,
  parameter int KEYS_PER_ROW     = kpsc_pkg::KEYS_DEF,
  parameter int TICKS_PER_PERIOD = kpsc_pkg::TICKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  kpsc_in_if.sink     in_ch,
  kpsc_out_if.source  out_ch
);
  import kpsc_pkg::*;

  localparam logic [7:0] QUARTER = 8'(TICKS_PER_PERIOD / 4);
  localparam logic [7:0] KEYS    = 8'(KEYS_PER_ROW);
  localparam logic [7:0] TICKS   = 8'(TICKS_PER_PERIOD);

  logic [7:0] blink_r, blink_nxt;
  logic [7:0] chase_r, chase_nxt;
  logic       linked_r;
  logic       led_r, led_nxt;

  logic       fire;
  logic       in_ready;
  logic       tick;
  logic       linked;
  logic       clear;
  logic       chase_step;
  logic [7:0] chase_inc;
  logic [8:0] blink_inc;
  logic [6:0] sense [ROWS];

  kpsc_lane_ctl_t lane_ctl   [ROWS];
  logic [6:0]     lane_drive [ROWS];
  logic           lane_press [ROWS];
  logic [4:0]     lane_key   [ROWS];

  assign in_ch.ready = in_ready;
  assign fire        = in_ch.valid && in_ready;
  assign tick        = (in_ch.cmd == CMD_TICK);
  assign linked      = in_ch.usb_configured;

  // Blink, LED and chase timing for a tick.
  always_comb begin
    led_nxt    = led_r;
    blink_nxt  = blink_r;
    chase_nxt  = chase_r;
    clear      = 1'b0;
    chase_step = 1'b0;
    chase_inc  = chase_r + 8'd1;
    blink_inc  = {1'b0, blink_r} + 9'd1;
    if (tick) begin
      if (linked) begin
        led_nxt = (blink_r < QUARTER ||
                   (blink_r >= 8'(2 * QUARTER) && blink_r < 8'(3 * QUARTER))) ? 1'b0 : 1'b1;
      end else begin
        led_nxt = (blink_r < 8'(2 * QUARTER)) ? 1'b0 : 1'b1;
      end
      clear      = (linked != linked_r);
      chase_step = !linked && (blink_r == 8'd0 || blink_r == QUARTER ||
                               blink_r == 8'(2 * QUARTER) || blink_r == 8'(3 * QUARTER));
      if (chase_step) begin
        chase_nxt = (chase_inc >= KEYS) ? 8'd0 : chase_inc;
      end
      blink_nxt = (blink_inc >= {1'b0, TICKS}) ? 8'd0 : blink_inc[7:0];
    end
  end

  // Shared timing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_r  <= 8'd0;
      chase_r  <= NO_KEY;
      linked_r <= 1'b0;
      led_r    <= 1'b1;
    end else if (fire) begin
      blink_r <= blink_nxt;
      chase_r <= chase_nxt;
      led_r   <= led_nxt;
      if (tick) begin
        linked_r <= linked;
      end
    end
  end

  // Row lanes: control decode, sense selection and one lane per row.
  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    localparam logic [7:0] BACK = (r <= 2) ? 8'(2 - r) : 8'd0;

    always_comb begin
      lane_ctl[r].upd        = !tick && (in_ch.update_row == 8'(r)) && (r <= 2);
      lane_ctl[r].upd_lamp   = in_ch.update_lamp;
      lane_ctl[r].scan       = tick && linked;
      lane_ctl[r].clear      = clear;
      lane_ctl[r].chase      = chase_step && (r <= 2);
      lane_ctl[r].chase_lamp = (chase_nxt >= BACK) ? (chase_nxt - BACK)
                                                   : (chase_nxt + KEYS - BACK);
    end

    if (r == 0) begin : g_s0
      assign sense[r] = in_ch.row0_sense;
    end else if (r == 1) begin : g_s1
      assign sense[r] = in_ch.row1_sense;
    end else if (r == 2) begin : g_s2
      assign sense[r] = in_ch.row2_sense;
    end else begin : g_sx
      assign sense[r] = SENSE_IDLE;
    end

    kpsc_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .fire      (fire),
      .ctl       (lane_ctl[r]),
      .sense     (sense[r]),
      .drive_nxt (lane_drive[r]),
      .press     (lane_press[r]),
      .press_key (lane_key[r])
    );
  end

  // Press selection and result buffering.
  kpsc_merge #(
    .ROWS (ROWS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (fire),
    .lane_drive (lane_drive),
    .lane_press (lane_press),
    .lane_key   (lane_key),
    .led_nxt    (led_nxt),
    .in_ready   (in_ready),
    .out_ch     (out_ch)
  );

endmodule

[dv/kpsc_scan_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the keypad row-scan lamp controller: keeps its own copy of
// the row scan, chase and status LED state and checks every result frame.
// Depends on kpsc_pkg, kpsc_in_if and kpsc_out_if.
module kpsc_scan_checker (
  input  logic clk,
  input  logic rst_n,
  kpsc_in_if   req_ch,
  kpsc_out_if  res_ch,
  output int   mismatches,
  output int   frames_due,
  output int   frames_checked,
  output int   presses_seen,
  output int   chase_steps
);
  import kpsc_pkg::*;

  localparam int NROWS   = PORT_ROWS;
  localparam int KEYS    = KEYS_DEF;
  localparam int TICKS   = TICKS_DEF;
  localparam int QUARTER = TICKS / 4;

  // Group bits of a drive or sense word, all active low.
  localparam logic [6:0] GRP_LO  = 7'h40;
  localparam logic [6:0] GRP_MID = 7'h20;
  localparam logic [6:0] GRP_HI  = 7'h10;

  typedef enum logic [1:0] {
    SCAN_IDLE  = 2'd0,
    SCAN_ARMED = 2'd1,
    SCAN_HELD  = 2'd2
  } scan_phase_t;

  logic [7:0]  held_key [NROWS];
  scan_phase_t phase [NROWS];
  logic [6:0]  drive [NROWS];
  logic [6:0]  blink_count;
  logic [7:0]  chase_pos;
  logic        link_seen;
  logic        led_level;

  kpsc_res_t lamp_frames_due[$];
  kpsc_res_t frame_got;
  kpsc_res_t frame_want;
  kpsc_res_t frame_new;

  // Drive word that lights one key: group bit from key[7:3], index from key[2:0].
  function automatic logic [6:0] drive_for_key(input logic [7:0] key);
    logic [6:0] code;
    case (key[7:3])
      5'd0:    code = DRIVE_BASE & ~GRP_LO;
      5'd1:    code = DRIVE_BASE & ~GRP_MID;
      5'd2:    code = DRIVE_BASE & ~GRP_HI;
      default: code = DRIVE_BASE;
    endcase
    code[3:1] = code[3:1] | key[2:0];
    return code;
  endfunction

  task automatic reset_panel();
    for (int r = 0; r < NROWS; r++) begin
      held_key[r] = 8'd0;
      phase[r]    = SCAN_IDLE;
      drive[r]    = drive_for_key(8'd0);
    end
    blink_count = '0;
    chase_pos   = 8'hFF;
    link_seen   = 1'b0;
    led_level   = 1'b1;
  endtask

  // Advance the panel by one request and build the frame it should produce.
  task automatic advance_panel(output kpsc_res_t frame);
    logic [6:0] sense;
    logic       linked;
    logic       down;
    logic       grouped;
    int         t;
    frame = '0;
    if (req_ch.cmd == CMD_UPDATE) begin
      // Host lamp update: only rows that exist are touched.
      if (req_ch.update_row < NROWS) begin
        held_key[req_ch.update_row[1:0]] = req_ch.update_lamp;
        phase[req_ch.update_row[1:0]]    = SCAN_IDLE;
        drive[req_ch.update_row[1:0]]    = drive_for_key(req_ch.update_lamp);
      end
    end else begin
      linked = req_ch.usb_configured;
      t      = blink_count;
      // Linked: on in first and third quarter. Unlinked: on in first half.
      if (linked) begin
        led_level = !(t < QUARTER || (t >= 2 * QUARTER && t < 3 * QUARTER));
      end else begin
        led_level = !(t < 2 * QUARTER);
      end
      // A change of link state drops every row to no key.
      if (linked != link_seen) begin
        link_seen = linked;
        for (int r = 0; r < NROWS; r++) begin
          held_key[r] = NO_KEY;
          phase[r]    = SCAN_IDLE;
          drive[r]    = drive_for_key(NO_KEY);
        end
      end
      if (linked) begin
        // Row scan; a later row overwrites the press of an earlier one.
        for (int r = 0; r < NROWS; r++) begin
          sense = (r == 0) ? req_ch.row0_sense :
                  (r == 1) ? req_ch.row1_sense : req_ch.row2_sense;
          down  = !sense[0];
          case (phase[r])
            SCAN_IDLE: begin
              if (down) begin
                drive[r] = DRIVE_BLANK;
                phase[r] = SCAN_ARMED;
              end
            end
            SCAN_ARMED: begin
              if (down) begin
                grouped = 1'b1;
                if (!sense[4]) begin
                  held_key[r] = 8'd16 + {5'd0, sense[3:1]};
                end else if (!sense[5]) begin
                  held_key[r] = 8'd8 + {5'd0, sense[3:1]};
                end else if (!sense[6]) begin
                  held_key[r] = {5'd0, sense[3:1]};
                end else begin
                  grouped = 1'b0;
                end
                drive[r] = drive_for_key(held_key[r]);
                phase[r] = SCAN_HELD;
                if (grouped) begin
                  frame.press_valid = 1'b1;
                  frame.press_row   = 2'(r);
                  frame.press_key   = held_key[r][4:0];
                end
              end else begin
                drive[r] = drive_for_key(held_key[r]);
                phase[r] = SCAN_IDLE;
              end
            end
            SCAN_HELD: begin
              if (!down) begin
                phase[r] = SCAN_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
      end else if (t == 0 || t == QUARTER || t == 2 * QUARTER || t == 3 * QUARTER) begin
        // Chase step: row 2 leads, rows 1 and 0 trail by one and two keys.
        chase_pos = chase_pos + 8'd1;
        if (chase_pos >= KEYS) begin
          chase_pos = 8'd0;
        end
        drive[2] = drive_for_key(chase_pos);
        drive[1] = drive_for_key(8'((int'(chase_pos) + KEYS - 1) % KEYS));
        drive[0] = drive_for_key(8'((int'(chase_pos) + KEYS - 2) % KEYS));
        chase_steps++;
      end
      blink_count = (int'(blink_count) + 1 >= TICKS) ? 7'd0 : blink_count + 7'd1;
    end
    frame.lamp_drive0 = drive[0];
    frame.lamp_drive1 = drive[1];
    frame.lamp_drive2 = drive[2];
    frame.status_led  = led_level;
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
               $time, name, want_v, got_v);
    end
  endtask

  initial begin
    mismatches     = 0;
    frames_due     = 0;
    frames_checked = 0;
    presses_seen   = 0;
    chase_steps    = 0;
    reset_panel();
  end

  // Results are checked before the request of the same edge is modeled.
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_panel();
      lamp_frames_due.delete();
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        frame_got.lamp_drive0 = res_ch.lamp_drive0;
        frame_got.lamp_drive1 = res_ch.lamp_drive1;
        frame_got.lamp_drive2 = res_ch.lamp_drive2;
        frame_got.status_led  = res_ch.status_led;
        frame_got.press_valid = res_ch.press_valid;
        frame_got.press_row   = res_ch.press_row;
        frame_got.press_key   = res_ch.press_key;
        if (lamp_frames_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual 0x%0h",
                   $time, frame_got);
        end else begin
          frame_want = lamp_frames_due.pop_front();
          frames_checked++;
          check_field("lamp_drive0", frame_want.lamp_drive0, frame_got.lamp_drive0);
          check_field("lamp_drive1", frame_want.lamp_drive1, frame_got.lamp_drive1);
          check_field("lamp_drive2", frame_want.lamp_drive2, frame_got.lamp_drive2);
          check_field("status_led", frame_want.status_led, frame_got.status_led);
          check_field("press_valid", frame_want.press_valid, frame_got.press_valid);
          check_field("press_row", frame_want.press_row, frame_got.press_row);
          check_field("press_key", frame_want.press_key, frame_got.press_key);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        advance_panel(frame_new);
        if (frame_new.press_valid) begin
          presses_seen++;
        end
        lamp_frames_due.push_back(frame_new);
      end
    end
    frames_due = lamp_frames_due.size();
  end

endmodule

[dv/keypad_row_scan_lamp_controller_top_test.sv]
`timescale 1ns / 1ps
// Testbench top for the keypad row-scan lamp controller: clock, reset,
// request stimulus, result back-pressure, watchdog and the verdict.
// Depends on kpsc_pkg, kpsc_in_if, kpsc_out_if, the block and kpsc_scan_checker.
module keypad_row_scan_lamp_controller_top_test;
  import kpsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst_n;

  kpsc_in_if  in_ch ();
  kpsc_out_if out_ch ();

  int mismatches;
  int frames_due;
  int frames_checked;
  int presses_seen;
  int chase_steps;

  int gap_pct;
  int stall_pct;
  int stall_left;
  int sent_ticks;
  int sent_updates;
  int idle_cycles;

  // Per-row model of a finger on the keypad for the random part.
  logic       key_down [3];
  logic [6:0] key_sense [3];

  keypad_row_scan_lamp_controller_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kpsc_scan_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_ch         (in_ch),
    .res_ch         (out_ch),
    .mismatches     (mismatches),
    .frames_due     (frames_due),
    .frames_checked (frames_checked),
    .presses_seen   (presses_seen),
    .chase_steps    (chase_steps)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result back-pressure: ready is dropped in random stall bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: too many cycles in a row with no request or result moving.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("keypad_row_scan_lamp_controller_top_test NOT OK");
      $finish;
    end
  end

  // Drive one request at a falling edge and hold it until it is accepted.
  task automatic send_request(input logic cmd, input logic link, input logic [6:0] s0,
                              input logic [6:0] s1, input logic [6:0] s2,
                              input logic [7:0] urow, input logic [7:0] ulamp);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.cmd            <= cmd;
    in_ch.usb_configured <= link;
    in_ch.row0_sense     <= s0;
    in_ch.row1_sense     <= s1;
    in_ch.row2_sense     <= s2;
    in_ch.update_row     <= urow;
    in_ch.update_lamp    <= ulamp;
    in_ch.valid          <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Tick request; the update fields carry noise.
  task automatic tick(input logic link, input logic [6:0] s0, input logic [6:0] s1,
                      input logic [6:0] s2);
    logic [7:0] noise_row;
    logic [7:0] noise_lamp;
    noise_row  = 8'($urandom);
    noise_lamp = 8'($urandom);
    sent_ticks++;
    send_request(CMD_TICK, link, s0, s1, s2, noise_row, noise_lamp);
  endtask

  // Host lamp update; the tick fields carry noise.
  task automatic host_update(input logic [7:0] row, input logic [7:0] lamp);
    logic [6:0] noise [3];
    logic       noise_link;
    noise_link = 1'($urandom);
    for (int r = 0; r < 3; r++) begin
      noise[r] = 7'($urandom);
    end
    sent_updates++;
    send_request(CMD_UPDATE, noise_link, noise[0], noise[1], noise[2], row, lamp);
  endtask

  // Released key: bit 0 high, the rest random.
  function automatic logic [6:0] open_sense();
    logic [6:0] v;
    v = 7'($urandom);
    v[0] = 1'b1;
    return v;
  endfunction

  // Pressed key: mostly a single group low, sometimes none or several.
  function automatic logic [6:0] pick_press();
    logic [6:0] v;
    int         mode;
    v = 7'($urandom);
    v[0] = 1'b0;
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      v[6:4] = 3'b111;
      v[4 + $urandom_range(0, 2)] = 1'b0;
    end else if (mode == 7) begin
      v[6:4] = 3'b111;
    end
    return v;
  endfunction

  // Tick with keys going down and up at random, held over several ticks.
  task automatic random_tick(input int link_pct);
    logic [6:0] s [3];
    for (int r = 0; r < 3; r++) begin
      if ($urandom_range(0, 3) == 0) begin
        key_down[r] = !key_down[r];
        if (key_down[r]) begin
          key_sense[r] = pick_press();
        end
      end else if (key_down[r] && $urandom_range(0, 9) == 0) begin
        key_sense[r] = pick_press();
      end
      s[r] = key_down[r] ? key_sense[r] : open_sense();
    end
    tick($urandom_range(0, 99) < link_pct, s[0], s[1], s[2]);
  endtask

  task automatic random_update();
    logic [7:0] row;
    logic [7:0] lamp;
    row  = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2));
    lamp = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 23));
    host_update(row, lamp);
  endtask

  task automatic run_random(input int count, input int link_pct, input int upd_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < upd_pct) begin
        random_update();
      end else begin
        random_tick(link_pct);
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_TICK;
    in_ch.usb_configured = 1'b0;
    in_ch.row0_sense     = SENSE_IDLE;
    in_ch.row1_sense     = SENSE_IDLE;
    in_ch.row2_sense     = SENSE_IDLE;
    in_ch.update_row     = 8'd0;
    in_ch.update_lamp    = 8'd0;
    out_ch.ready         = 1'b0;
    gap_pct              = 0;
    stall_pct            = 20;
    stall_left           = 0;
    sent_ticks           = 0;
    sent_updates         = 0;
    idle_cycles          = 0;
    for (int r = 0; r < 3; r++) begin
      key_down[r]  = 1'b0;
      key_sense[r] = SENSE_IDLE;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Unlinked first tick: the chase wraps from 255 to key 0.
    tick(1'b0, 7'h00, 7'h00, 7'h00);
    // Host updates: every group, lamps past 23, rows past the last one.
    host_update(8'd0, 8'd0);
    host_update(8'd1, 8'd23);
    host_update(8'd2, 8'd255);
    host_update(8'd3, 8'd5);
    host_update(8'd255, 8'd7);
    host_update(8'd2, 8'd24);
    host_update(8'd1, 8'd8);
    host_update(8'd0, 8'd16);
    // Linking clears all rows to no key.
    tick(1'b1, SENSE_IDLE, SENSE_IDLE, SENSE_IDLE);
    // Presses on all rows at once (keys 23, 8, 5); the highest row is reported.
    tick(1'b1, 7'b1101110, 7'b1010000, 7'b0111010);
    tick(1'b1, 7'b1101110, 7'b1010000, 7'b0111010);
    tick(1'b1, SENSE_IDLE, SENSE_IDLE, SENSE_IDLE);
    // No group low on row 0, all groups low on row 1, two groups low on row 2.
    tick(1'b1, 7'b1110110, 7'b0000100, 7'b0010010);
    tick(1'b1, 7'b1110110, 7'b0000100, 7'b0010010);
    tick(1'b1, SENSE_IDLE, SENSE_IDLE, SENSE_IDLE);
    // Key let go before it is confirmed: the held lamp comes back.
    tick(1'b1, 7'b1101110, SENSE_IDLE, SENSE_IDLE);
    tick(1'b1, SENSE_IDLE, SENSE_IDLE, SENSE_IDLE);
    host_update(8'd1, 8'd12);
    // All sense bits low on every row.
    tick(1'b1, 7'h00, 7'h00, 7'h00);
    tick(1'b1, 7'h00, 7'h00, 7'h00);
    // Unlinking clears again.
    tick(1'b0, SENSE_IDLE, SENSE_IDLE, SENSE_IDLE);
    host_update(8'd2, 8'd3);

    // Mostly linked: key presses with random content.
    gap_pct   = 15;
    stall_pct = 12;
    run_random(150, 97, 15);

    // Hold off the next request until every result is back.
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (frames_due != 0);

    // Mostly unlinked: chase and the unlinked LED pattern over a full period.
    run_random(120, 3, 6);
    run_random(100, 90, 12);

    // Closing stretch at full rate on both sides.
    gap_pct   = 0;
    stall_pct = 0;
    run_random(80, 90, 12);

    in_ch.valid <= 1'b0;
    do @(negedge clk); while (frames_due != 0);
    repeat (4) @(posedge clk);

    $display("Sent %0d ticks and %0d host lamp updates; %0d result frames checked.",
             sent_ticks, sent_updates, frames_checked);
    $display("Key presses reported: %0d; chase steps: %0d.", presses_seen, chase_steps);
    if (mismatches == 0 && frames_due == 0) begin
      $display("keypad_row_scan_lamp_controller_top_test OK");
    end else begin
      $display("keypad_row_scan_lamp_controller_top_test NOT OK");
    end
    $finish;
  end

endmodule

[keypad_row_scan_lamp_controller_top.f]
design/kpsc_pkg.sv
design/kpsc_in_if.sv
design/kpsc_out_if.sv
design/kpsc_lane.sv
design/kpsc_merge.sv
design/keypad_row_scan_lamp_controller_top.sv
dv/kpsc_scan_checker.sv
dv/keypad_row_scan_lamp_controller_top_test.sv
